FILE: sv/tvge_pkg.sv
// shared types and constants for the three-valued gate evaluator
`default_nettype none

package tvge_pkg;

	localparam int unsigned DATA_W           = 64;
	localparam int unsigned PATTERN_BITS_DEF = 64;

	typedef enum logic [2:0] {
		GATE_BUF  = 3'd0,
		GATE_INV  = 3'd1,
		GATE_AND  = 3'd2,
		GATE_NAND = 3'd3,
		GATE_OR   = 3'd4,
		GATE_NOR  = 3'd5,
		GATE_XOR  = 3'd6,
		GATE_XNOR = 3'd7
	} gate_t;

	typedef struct packed {
		logic  load;
		logic  first;
		gate_t kind;
	} lane_ctrl_t;

	function automatic logic is_inverting(input gate_t kind);
		logic inv;
		case (kind)
			GATE_INV, GATE_NAND, GATE_NOR, GATE_XNOR: inv = 1'b1;
			default:                                  inv = 1'b0;
		endcase
		return inv;
	endfunction

endpackage

`default_nettype wire

FILE: sv/tvge_lane.sv
// one pattern bit: dual-rail accumulator and fold logic
`default_nettype none

module tvge_lane (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire tvge_pkg::lane_ctrl_t ctrl,
	input  wire                 bx,
	input  wire                 bp,
	output logic                rx,
	output logic                rp
);

	logic acc_x_q;
	logic acc_p_q;
	logic nx;
	logic np;

	always_comb begin
		nx = acc_x_q;
		np = acc_p_q;
		if (ctrl.first) begin
			nx = bx;
			np = bp;
		end else begin
			case (ctrl.kind)
				tvge_pkg::GATE_AND, tvge_pkg::GATE_NAND: begin
					nx = acc_x_q & bx;
					np = acc_p_q | bp;
				end
				tvge_pkg::GATE_OR, tvge_pkg::GATE_NOR: begin
					nx = acc_x_q | bx;
					np = acc_p_q & bp;
				end
				tvge_pkg::GATE_XOR, tvge_pkg::GATE_XNOR: begin
					nx = (acc_x_q & bp) | (acc_p_q & bx);
					np = (acc_p_q | bx) & (acc_x_q | bp);
				end
				default: begin
					nx = acc_x_q;
					np = acc_p_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q <= 1'b0;
			acc_p_q <= 1'b0;
		end else if (ctrl.load) begin
			acc_x_q <= nx;
			acc_p_q <= np;
		end
	end

	assign rx = tvge_pkg::is_inverting(ctrl.kind) ? np : nx;
	assign rp = tvge_pkg::is_inverting(ctrl.kind) ? nx : np;

endmodule

`default_nettype wire

FILE: sv/tvge_merge.sv
// output stage: gathers lane results into the registered result
`default_nettype none

module tvge_merge #(
	parameter int unsigned PATTERN_BITS = tvge_pkg::PATTERN_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              capture,
	input  wire  [PATTERN_BITS-1:0]          lane_x,
	input  wire  [PATTERN_BITS-1:0]          lane_p,
	output logic                             res_valid,
	input  wire                              res_ready,
	output logic [tvge_pkg::DATA_W-1:0]      result_x,
	output logic [tvge_pkg::DATA_W-1:0]      result_p
);

	logic                        valid_q;
	logic [tvge_pkg::DATA_W-1:0] pad_x;
	logic [tvge_pkg::DATA_W-1:0] pad_p;
	logic [tvge_pkg::DATA_W-1:0] res_x_q;
	logic [tvge_pkg::DATA_W-1:0] res_p_q;

	always_comb begin
		pad_x = '0;
		pad_p = '0;
		pad_x[PATTERN_BITS-1:0] = lane_x;
		pad_p[PATTERN_BITS-1:0] = lane_p;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready || !valid_q) begin
			valid_q <= capture;
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			res_x_q <= pad_x;
			res_p_q <= pad_p;
		end
	end

	assign res_valid = valid_q;
	assign result_x  = res_x_q;
	assign result_p  = res_p_q;

endmodule

`default_nettype wire

FILE: sv/three_valued_gate_evaluator.sv
// top level of the three-valued gate evaluator
`default_nettype none

// Evaluates one logic gate over PATTERN_BITS test patterns at once in dual-rail
// three-valued form (0 = x0/p1, 1 = x1/p0, X = x1/p1). Each request carries one
// gate input; the first input of a gate loads the accumulator, later ones fold
// in by the request's gate type, and the request marked last_operand produces
// one result (rails swapped for inverting types). Pattern bits at or above
// PATTERN_BITS read as zero. One request is taken every cycle unless a result
// is held by res_ready low: each pattern bit has its own lane whose fold is a
// single level of logic into its accumulator, and the result sits in an output
// register the cycle after the last request, while further requests flow on.
module three_valued_gate_evaluator #(
	parameter int unsigned PATTERN_BITS = tvge_pkg::PATTERN_BITS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         req_valid,
	output logic                        req_ready,
	input  wire  [2:0]                  command,
	input  wire  [tvge_pkg::DATA_W-1:0] operand_x,
	input  wire  [tvge_pkg::DATA_W-1:0] operand_p,
	input  wire                         last_operand,
	output logic                        res_valid,
	input  wire                         res_ready,
	output logic [tvge_pkg::DATA_W-1:0] result_x,
	output logic [tvge_pkg::DATA_W-1:0] result_p
);

	logic                  first_q;
	logic                  accept;
	tvge_pkg::lane_ctrl_t  ctrl;
	logic [PATTERN_BITS-1:0] lane_x;
	logic [PATTERN_BITS-1:0] lane_p;

	assign req_ready  = !res_valid || res_ready;
	assign accept     = req_valid && req_ready;
	assign ctrl.load  = accept;
	assign ctrl.first = first_q;
	assign ctrl.kind  = tvge_pkg::gate_t'(command);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (accept) begin
			first_q <= last_operand;
		end
	end

	for (genvar i = 0; i < PATTERN_BITS; i++) begin : g_lane
		tvge_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.bx     (operand_x[i]),
			.bp     (operand_p[i]),
			.rx     (lane_x[i]),
			.rp     (lane_p[i])
		);
	end

	tvge_merge #(
		.PATTERN_BITS (PATTERN_BITS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.capture   (accept && last_operand),
		.lane_x    (lane_x),
		.lane_p    (lane_p),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.result_x  (result_x),
		.result_p  (result_p)
	);

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// self-checking testbench for the three-valued gate evaluator
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import tvge_pkg::*;

	localparam int unsigned PATTERN_BITS = PATTERN_BITS_DEF;
	localparam int ITEM_GOAL = 1550;
	localparam int CYCLE_LIMIT = 200000;

	typedef logic [DATA_W-1:0] rail_t;
	typedef struct {
		rail_t x;
		rail_t p;
	} rail_pair_t;

	localparam rail_t ONES = '1;
	localparam rail_t ALT = {(DATA_W / 2){2'b10}};

	class gate_scoreboard;
		rail_t acc_x;
		rail_t acc_p;
		bit await_first;
		rail_t lane_mask;
		rail_pair_t gate_outputs_q[$];
		int failures;

		function new();
			acc_x = '0;
			acc_p = '0;
			await_first = 1'b1;
			lane_mask = ONES >> (DATA_W - PATTERN_BITS);
			failures = 0;
		endfunction

		function int outstanding();
			return gate_outputs_q.size();
		endfunction

		function void note_request(gate_t kind, rail_t bx_in, rail_t bp_in, logic last);
			rail_t bx;
			rail_t bp;
			rail_t ax;
			rail_t ap;
			rail_pair_t out;
			bx = bx_in & lane_mask;
			bp = bp_in & lane_mask;
			ax = acc_x;
			ap = acc_p;
			if (await_first) begin
				acc_x = bx;
				acc_p = bp;
			end else begin
				case (kind)
					GATE_AND, GATE_NAND: begin
						acc_x = ax & bx;
						acc_p = ap | bp;
					end
					GATE_OR, GATE_NOR: begin
						acc_x = ax | bx;
						acc_p = ap & bp;
					end
					GATE_XOR, GATE_XNOR: begin
						acc_x = (ax & bp) | (ap & bx);
						acc_p = (ap | bx) & (ax | bp);
					end
					default: begin
					end
				endcase
			end
			await_first = last;
			if (last) begin
				case (kind)
					GATE_INV, GATE_NAND, GATE_NOR, GATE_XNOR: begin
						out.x = acc_p & lane_mask;
						out.p = acc_x & lane_mask;
					end
					default: begin
						out.x = acc_x & lane_mask;
						out.p = acc_p & lane_mask;
					end
				endcase
				gate_outputs_q.push_back(out);
			end
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $realtime, msg);
			failures++;
		endtask

		task check_result(rail_t rx, rail_t rp);
			rail_pair_t want;
			if (gate_outputs_q.size() == 0) begin
				report($sformatf("unexpected result x=%h p=%h", rx, rp));
			end else begin
				want = gate_outputs_q.pop_front();
				if (rx !== want.x)
					report($sformatf("result_x got %h expected %h", rx, want.x));
				if (rp !== want.p)
					report($sformatf("result_p got %h expected %h", rp, want.p));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	gate_t command = GATE_BUF;
	rail_t operand_x = '0;
	rail_t operand_p = '0;
	logic last_operand = 1'b0;
	logic res_valid;
	logic res_ready = 1'b0;
	rail_t result_x;
	rail_t result_p;

	gate_scoreboard sb = new();
	int sender_idle_pct = 0;
	int stall_pct = 0;
	int requests_sent = 0;
	int cycles = 0;

	three_valued_gate_evaluator #(
		.PATTERN_BITS(PATTERN_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.command(command),
		.operand_x(operand_x),
		.operand_p(operand_p),
		.last_operand(last_operand),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.result_x(result_x),
		.result_p(result_p)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		res_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			sb.check_result(result_x, result_p);
	end

	task automatic send_request(gate_t kind, rail_t x, rail_t p, logic last);
		while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		command <= kind;
		operand_x <= x;
		operand_p <= p;
		last_operand <= last;
		do
			@(posedge clk);
		while (!req_ready);
		sb.note_request(kind, x, p, last);
		requests_sent++;
	endtask

	// mostly well-formed 0/1/X codes, some raw rails and some flat extremes
	function automatic void make_rails(output rail_t x, output rail_t p);
		rail_t val;
		rail_t unk;
		val = {$urandom, $urandom};
		unk = {$urandom, $urandom} & {$urandom, $urandom};
		case ($urandom_range(9))
			0: begin
				x = {$urandom, $urandom};
				p = {$urandom, $urandom};
			end
			1: begin
				x = $urandom_range(1) ? ONES : '0;
				p = $urandom_range(1) ? ONES : '0;
			end
			default: begin
				x = val | unk;
				p = ~val | unk;
			end
		endcase
	endfunction

	task automatic send_random_gate();
		int n_ops;
		bit mixed;
		gate_t kind;
		rail_t x;
		rail_t p;
		n_ops = ($urandom_range(9) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
		mixed = ($urandom_range(4) == 0);
		kind = gate_t'($urandom_range(7));
		for (int i = 0; i < n_ops; i++) begin
			if (mixed)
				kind = gate_t'($urandom_range(7));
			make_rails(x, p);
			send_request(kind, x, p, i == n_ops - 1);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-operand gates incl. X and invalid code, then multi-input and/nand/or/nor
		send_request(GATE_BUF, ONES, ONES, 1'b1);
		send_request(GATE_INV, '0, '0, 1'b1);
		send_request(GATE_AND, ONES, '0, 1'b0);
		send_request(GATE_AND, ALT, ~ALT, 1'b0);
		send_request(GATE_AND, ONES, ONES, 1'b1);
		send_request(GATE_NAND, ALT, ~ALT, 1'b0);
		send_request(GATE_NAND, ~ALT, ALT, 1'b1);
		send_request(GATE_OR, '0, ONES, 1'b0);
		send_request(GATE_OR, ALT, ONES, 1'b1);
		send_request(GATE_NOR, ONES, '0, 1'b0);
		send_request(GATE_NOR, '0, ONES, 1'b1);
		// three-input xor and two-input xnor
		send_request(GATE_XOR, ALT, ~ALT, 1'b0);
		send_request(GATE_XOR, ONES, '0, 1'b0);
		send_request(GATE_XOR, ONES, ONES, 1'b1);
		send_request(GATE_XNOR, ~ALT, ALT, 1'b0);
		send_request(GATE_XNOR, ~ALT, ALT, 1'b1);
		// extra operands on buf and inv are ignored
		send_request(GATE_BUF, ALT, ~ALT, 1'b0);
		send_request(GATE_BUF, ONES, ONES, 1'b0);
		send_request(GATE_BUF, '0, '0, 1'b1);
		send_request(GATE_INV, ~ALT, ALT, 1'b0);
		send_request(GATE_INV, ONES, ONES, 1'b1);
		// mixed gate types in one gate
		send_request(GATE_AND, ONES, '0, 1'b0);
		send_request(GATE_XOR, ALT, ~ALT, 1'b0);
		send_request(GATE_NOR, '0, ONES, 1'b1);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					sender_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 79;
					stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					stall_pct = 79;
				end
				default: begin
					sender_idle_pct = 8;
					stall_pct = 8;
				end
			endcase
			while (requests_sent < (ph + 1) * ITEM_GOAL / 4)
				send_random_gate();
		end
		req_valid <= 1'b0;

		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

FILE: filelist.f
sv/tvge_pkg.sv
sv/tvge_lane.sv
sv/tvge_merge.sv
sv/three_valued_gate_evaluator.sv
tb/testbench.sv
